// ===== rtl/ppiad_pkg.sv =====
// Shared types, constants and register indexes of the afterglow decay unit.
`default_nettype none

package ppiad_pkg;

	localparam int unsigned COLUMNS_DEF = 1024;
	localparam int unsigned ROWS_DEF    = 1024;

	localparam int unsigned COORD_W = 11;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned FLOOR_W = 13;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DECAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_GATE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 3'd4;

	localparam logic [LEVEL_W-1:0] NORMAL_DECAY_RST = 8'd65;
	localparam logic [LEVEL_W-1:0] TAIL_DECAY_RST   = 8'd30;
	localparam logic [LEVEL_W-1:0] TAIL_GATE_RST    = 8'd200;
	localparam logic               TAIL_ENABLE_RST  = 1'b1;
	localparam logic [FLOOR_W-1:0] FLOOR_LEVEL_RST  = 13'd40;

	localparam logic OP_DECAY = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [LEVEL_W-1:0] load_level;
		logic               load_mark;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
		logic [LEVEL_W-1:0] new_level;
		logic               table_select;
		logic               new_mark;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_en;
		logic rd_en;
		logic wr_load;
		logic wr_decay;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic is_load;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/ppi_afterglow_decay_unit.sv =====
// Top level of the radar display afterglow decay unit.
`default_nettype none

// After reset the unit clears its COLUMNS x ROWS pixel store one entry per cycle, so busy
// stays high until all COLUMNS*ROWS entries (1048576 at the default size) are cleared;
// configuration writes are taken during that time. An item is taken when start is high and
// busy is low. A decay item inside the display goes through capture, store read and
// write-back, and its result shows on result for the single cycle that result_valid is
// high; the receiver must take it then. A load item is captured and then written to the
// store, an item outside the display is captured and dropped, and neither gives a result.
// A new item is taken only once the unit is back in idle. cfg_ready is always high.
module ppi_afterglow_decay_unit #(
	parameter int unsigned COLUMNS = ppiad_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = ppiad_pkg::ROWS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  ppiad_pkg::in_item_t               item,
	output logic                              busy,
	output logic                              result_valid,
	output ppiad_pkg::out_item_t              result,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [ppiad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ppiad_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ppiad_pkg::cmd_t    cmd;
	ppiad_pkg::status_t status;

	assign cfg_ready = 1'b1;

	ppiad_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	ppiad_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== rtl/ppiad_ctrl.sv =====
// Controller state machine: clearing pass, item capture, read and write-back sequencing.
`default_nettype none

module ppiad_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  ppiad_pkg::status_t  status,
	output ppiad_pkg::cmd_t     cmd,
	output logic                busy,
	output logic                result_valid
);

	ppiad_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppiad_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		busy         = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			ppiad_pkg::ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = ppiad_pkg::ST_IDLE;
				end
			end
			ppiad_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ppiad_pkg::ST_READ;
				end
			end
			ppiad_pkg::ST_READ: begin
				if (!status.in_range) begin
					state_d = ppiad_pkg::ST_IDLE;
				end else if (status.is_load) begin
					cmd.wr_load = 1'b1;
					state_d     = ppiad_pkg::ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ppiad_pkg::ST_WRITE;
				end
			end
			ppiad_pkg::ST_WRITE: begin
				cmd.wr_decay = 1'b1;
				result_valid = 1'b1;
				state_d      = ppiad_pkg::ST_IDLE;
			end
			default: begin
				state_d = ppiad_pkg::ST_IDLE;
			end
		endcase
	end

	a_result_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.rd_en))
		else $error("result without a preceding store read");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy)
		else $error("block not idle after result");

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ppiad_pkg::ST_READ))
		else $error("accepted transaction did not advance to read");

	a_no_write_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_en && (cmd.wr_load || cmd.wr_decay)))
		else $error("clearing pass collides with a store write");

endmodule

`default_nettype wire

// ===== rtl/ppiad_datapath.sv =====
// Datapath: configuration registers, pixel store, clear counter and decay arithmetic.
`default_nettype none

module ppiad_datapath #(
	parameter int unsigned COLUMNS = ppiad_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = ppiad_pkg::ROWS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  ppiad_pkg::in_item_t                    item,
	input  ppiad_pkg::cmd_t                        cmd,
	input  wire                                    cfg_wr,
	input  wire [ppiad_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [ppiad_pkg::CFG_DATA_W-1:0]        cfg_data,
	output ppiad_pkg::status_t                     status,
	output ppiad_pkg::out_item_t                   result
);

	localparam int unsigned DEPTH = COLUMNS * ROWS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned LW    = ppiad_pkg::LEVEL_W;
	localparam int unsigned EW    = LW + 1;

	logic [LW-1:0]                   normal_decay_q;
	logic [LW-1:0]                   tail_decay_q;
	logic [LW-1:0]                   tail_gate_q;
	logic                            tail_enable_q;
	logic [ppiad_pkg::FLOOR_W-1:0]   floor_level_q;

	ppiad_pkg::in_item_t             item_q;
	logic [AW-1:0]                   clr_q;
	logic [AW-1:0]                   addr_c;
	logic [AW-1:0]                   addr_q;
	logic [AW-1:0]                   wr_addr;
	logic [EW-1:0]                   wr_data;
	logic                            wr_en;
	logic [EW-1:0]                   rd_q;
	logic [EW-1:0]                   mem [DEPTH];

	logic [LW-1:0]                   cur_level;
	logic                            cur_mark;
	logic [LW-1:0]                   tail_res;
	logic [LW-1:0]                   norm_res;
	logic [LW-1:0]                   nxt_level;
	logic                            nxt_mark;
	logic                            nxt_sel;

	function automatic logic [LW-1:0] decay(input logic [LW-1:0] level,
		input logic [LW-1:0] amount, input logic [ppiad_pkg::FLOOR_W-1:0] flr);
		logic [LW-1:0] diff;
		diff = level - amount;
		if ((level >= amount) && ({{(ppiad_pkg::FLOOR_W-LW){1'b0}}, diff} > flr)) begin
			return diff;
		end
		return '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_decay_q <= ppiad_pkg::NORMAL_DECAY_RST;
			tail_decay_q   <= ppiad_pkg::TAIL_DECAY_RST;
			tail_gate_q    <= ppiad_pkg::TAIL_GATE_RST;
			tail_enable_q  <= ppiad_pkg::TAIL_ENABLE_RST;
			floor_level_q  <= ppiad_pkg::FLOOR_LEVEL_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				ppiad_pkg::REG_NORMAL_DECAY: normal_decay_q <= cfg_data[LW-1:0];
				ppiad_pkg::REG_TAIL_DECAY:   tail_decay_q   <= cfg_data[LW-1:0];
				ppiad_pkg::REG_TAIL_GATE:    tail_gate_q    <= cfg_data[LW-1:0];
				ppiad_pkg::REG_TAIL_ENABLE:  tail_enable_q  <= cfg_data[0];
				ppiad_pkg::REG_FLOOR_LEVEL:  floor_level_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.rd_en) begin
			addr_q <= addr_c;
			rd_q   <= mem[addr_c];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign addr_c = AW'(32'(item_q.row) * 32'(COLUMNS) + 32'(item_q.col));

	assign status.clr_last = (clr_q == AW'(DEPTH - 1));
	assign status.in_range = (32'(item_q.col) < 32'(COLUMNS)) &&
	                         (32'(item_q.row) < 32'(ROWS));
	assign status.is_load  = (item_q.operation == ppiad_pkg::OP_LOAD);

	assign cur_level = rd_q[LW-1:0];
	assign cur_mark  = rd_q[LW];
	assign tail_res  = decay(cur_level, tail_decay_q, floor_level_q);
	assign norm_res  = decay(cur_level, normal_decay_q, floor_level_q);

	always_comb begin
		nxt_level = norm_res;
		nxt_mark  = cur_mark;
		nxt_sel   = 1'b0;
		if (tail_enable_q) begin
			if (cur_mark) begin
				nxt_level = tail_res;
				nxt_sel   = 1'b1;
			end else if ((cur_level > tail_gate_q) && (norm_res < tail_gate_q)) begin
				nxt_level = tail_gate_q;
				nxt_mark  = 1'b1;
				nxt_sel   = 1'b1;
			end
		end
	end

	always_comb begin
		wr_en   = cmd.clr_en || cmd.wr_load || cmd.wr_decay;
		wr_addr = addr_q;
		wr_data = {nxt_mark, nxt_level};
		if (cmd.clr_en) begin
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.wr_load) begin
			wr_addr = addr_c;
			wr_data = {item_q.load_mark, item_q.load_level};
		end
	end

	assign result.out_col      = item_q.col;
	assign result.out_row      = item_q.row;
	assign result.new_level    = nxt_level;
	assign result.table_select = nxt_sel;
	assign result.new_mark     = nxt_mark;

endmodule

`default_nettype wire
